/* sv/rhvc_pkg.sv */
package rhvc_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 64;

  localparam int ROW_W = 4;
  localparam int COL_W = 6;
  localparam int CNT_W = 7;
  localparam int ROWS_CFG_W = 5;
  localparam int COLS_CFG_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    MODE_LOAD      = 2'd0,
    MODE_ASSIGN    = 2'd1,
    MODE_RECOMPUTE = 2'd2,
    MODE_CHANGE    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_USED = 1'b0,
    REG_COLS_USED = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHG,
    ST_RC,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_ACC,
    CELL_STEP,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [COLS_CFG_W-1:0]  ncols;
  } cell_ctl_t;

  typedef struct packed {
    mode_t              mode;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic               bit_req;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [CNT_W-1:0]   violations;
    logic               last;
  } rsp_t;

endpackage

/* sv/rhvc_table.sv */
module rhvc_table (
  input  logic                             clk,
  input  logic                             we,
  input  logic [rhvc_pkg::COL_W-1:0]       wcol,
  input  logic [rhvc_pkg::ROW_W-1:0]       wrow,
  input  logic                             wbit,
  input  logic [rhvc_pkg::COL_W-1:0]       raddr,
  output logic [rhvc_pkg::MAX_ROWS-1:0]    rdata
);

  logic [rhvc_pkg::MAX_ROWS-1:0] mem [rhvc_pkg::MAX_COLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wcol][wrow] <= wbit;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/rhvc_cell.sv */
module rhvc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  rhvc_pkg::cell_ctl_t           ctl,
  input  logic                          en,
  input  logic                          diff,
  input  logic [rhvc_pkg::CNT_W-1:0]    nbr_cnt,
  output logic [rhvc_pkg::CNT_W-1:0]    cnt
);

  logic [rhvc_pkg::CNT_W-1:0] cnt_next;

  always_comb begin
    cnt_next = cnt;
    case (ctl.op)
      rhvc_pkg::CELL_CLEAR: begin
        if (en) cnt_next = '0;
      end
      rhvc_pkg::CELL_ACC: begin
        if (en && diff) cnt_next = cnt + 1'b1;
      end
      rhvc_pkg::CELL_STEP: begin
        if (en) begin
          if (diff) begin
            if (cnt < ctl.ncols) cnt_next = cnt + 1'b1;
          end else begin
            if (cnt != '0) cnt_next = cnt - 1'b1;
          end
        end
      end
      rhvc_pkg::CELL_ROTATE: begin
        cnt_next = nbr_cnt;
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

/* sv/row_hamming_violation_counter.sv */
// Row Hamming violation counter.
// Request channel (req_valid, req_stall, req) carries one transaction per
// operation: load a table bit, assign a variable bit, recompute every row in
// use, or change one variable. Response channel (rsp_valid, rsp_stall, rsp)
// returns one transaction per row in use, rows in ascending order, last
// set on the final row. Load, assign and a change that alters nothing or
// names a column not in use produce no response.
// Load and assign leave the block idle. A change reads the table word, updates
// the row counts and then rotates the row ring past the output register. A
// recompute reads the columns in use (one table word a cycle from the column
// memory) and then does the same rotation. req_stall is high from the
// accepting edge to the end of the rotation.
// Rsp stall freezes the ring while rows remain to report; the pending
// transaction holds in the output register.
// Reset (synchronous, active high) sets rows_used to 16, cols_used to 64,
// every variable bit and row count to zero. Table bits are undefined until
// loaded. cfg_we writes register cfg_index with cfg_data; write only when idle.
module row_hamming_violation_counter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  rhvc_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output rhvc_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [rhvc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rhvc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NR = rhvc_pkg::MAX_ROWS;

  rhvc_pkg::state_t                     state, state_next;
  logic [rhvc_pkg::ROWS_CFG_W-1:0]      rows_used;
  logic [rhvc_pkg::COLS_CFG_W-1:0]      cols_used;
  logic [rhvc_pkg::ROWS_CFG_W-1:0]      nrows;
  logic [rhvc_pkg::COLS_CFG_W-1:0]      ncols;
  logic [rhvc_pkg::MAX_COLS-1:0]        var_bits, var_bits_next;
  logic [rhvc_pkg::COLS_CFG_W-1:0]      col_cnt, col_cnt_next;
  logic [rhvc_pkg::ROW_W-1:0]           emit_idx, emit_idx_next;
  logic                                 abit, abit_next;
  logic [rhvc_pkg::COL_W-1:0]           rd_addr;
  logic [NR-1:0]                        rd_word;
  logic                                 tbl_we;
  logic                                 accept;
  logic                                 emitting;
  logic                                 rsp_free;
  logic                                 rsp_load;
  rhvc_pkg::cell_ctl_t                  ctl;
  logic [rhvc_pkg::CNT_W-1:0]           cnt [NR];

  assign accept = req_valid && !req_stall;
  assign req_stall = (state != rhvc_pkg::ST_IDLE);

  always_comb begin
    if (rows_used == '0) begin
      nrows = rhvc_pkg::ROWS_CFG_W'(1);
    end else if (rows_used > rhvc_pkg::ROWS_CFG_W'(NR)) begin
      nrows = rhvc_pkg::ROWS_CFG_W'(NR);
    end else begin
      nrows = rows_used;
    end
    if (cols_used == '0) begin
      ncols = rhvc_pkg::COLS_CFG_W'(1);
    end else if (cols_used > rhvc_pkg::COLS_CFG_W'(rhvc_pkg::MAX_COLS)) begin
      ncols = rhvc_pkg::COLS_CFG_W'(rhvc_pkg::MAX_COLS);
    end else begin
      ncols = cols_used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= rhvc_pkg::ROWS_CFG_W'(16);
      cols_used <= rhvc_pkg::COLS_CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        rhvc_pkg::REG_ROWS_USED: rows_used <= cfg_data[rhvc_pkg::ROWS_CFG_W-1:0];
        rhvc_pkg::REG_COLS_USED: cols_used <= cfg_data[rhvc_pkg::COLS_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign emitting = ({1'b0, emit_idx} < nrows);
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign rsp_load = (state == rhvc_pkg::ST_EMIT) && emitting && rsp_free;

  always_comb begin
    state_next    = state;
    var_bits_next = var_bits;
    col_cnt_next  = col_cnt;
    emit_idx_next = emit_idx;
    abit_next     = abit;
    rd_addr       = req.column;
    tbl_we        = 1'b0;
    ctl.op        = rhvc_pkg::CELL_HOLD;
    ctl.ncols     = ncols;
    case (state)
      rhvc_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.mode)
            rhvc_pkg::MODE_LOAD: begin
              tbl_we = 1'b1;
            end
            rhvc_pkg::MODE_ASSIGN: begin
              var_bits_next[req.column] = req.bit_req;
            end
            rhvc_pkg::MODE_RECOMPUTE: begin
              ctl.op       = rhvc_pkg::CELL_CLEAR;
              rd_addr      = '0;
              abit_next    = var_bits[0];
              col_cnt_next = rhvc_pkg::COLS_CFG_W'(1);
              state_next   = rhvc_pkg::ST_RC;
            end
            rhvc_pkg::MODE_CHANGE: begin
              if (var_bits[req.column] != req.bit_req) begin
                var_bits_next[req.column] = req.bit_req;
                if ({1'b0, req.column} < ncols) begin
                  abit_next  = req.bit_req;
                  state_next = rhvc_pkg::ST_CHG;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      rhvc_pkg::ST_CHG: begin
        ctl.op        = rhvc_pkg::CELL_STEP;
        emit_idx_next = '0;
        state_next    = rhvc_pkg::ST_EMIT;
      end
      rhvc_pkg::ST_RC: begin
        ctl.op = rhvc_pkg::CELL_ACC;
        if (col_cnt == ncols) begin
          emit_idx_next = '0;
          state_next    = rhvc_pkg::ST_EMIT;
        end else begin
          rd_addr      = col_cnt[rhvc_pkg::COL_W-1:0];
          abit_next    = var_bits[col_cnt[rhvc_pkg::COL_W-1:0]];
          col_cnt_next = col_cnt + 1'b1;
        end
      end
      rhvc_pkg::ST_EMIT: begin
        if (!emitting || rsp_free) begin
          ctl.op        = rhvc_pkg::CELL_ROTATE;
          emit_idx_next = emit_idx + 1'b1;
          if (emit_idx == rhvc_pkg::ROW_W'(NR - 1)) begin
            state_next = rhvc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = rhvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rhvc_pkg::ST_IDLE;
      var_bits <= '0;
      col_cnt  <= '0;
      emit_idx <= '0;
    end else begin
      state    <= state_next;
      var_bits <= var_bits_next;
      col_cnt  <= col_cnt_next;
      emit_idx <= emit_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    abit <= abit_next;
  end

  rhvc_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .wcol  (req.column),
    .wrow  (req.row),
    .wbit  (req.bit_req),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  for (genvar i = 0; i < NR; i++) begin : g_cell
    rhvc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .en      (rhvc_pkg::ROWS_CFG_W'(i) < nrows),
      .diff    (rd_word[i] ^ abit),
      .nbr_cnt (cnt[(i + 1) % NR]),
      .cnt     (cnt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.row_index  <= emit_idx;
      rsp.violations <= cnt[0];
      rsp.last       <= (({1'b0, emit_idx} + 1'b1) == nrows);
    end
  end

  a_rc_starts: assert property (@(posedge clk) disable iff (rst)
    accept && req.mode == rhvc_pkg::MODE_RECOMPUTE |=> state == rhvc_pkg::ST_RC)
    else $error("recompute did not start the column walk");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == rhvc_pkg::MODE_LOAD || req.mode == rhvc_pkg::MODE_ASSIGN)
    |=> state == rhvc_pkg::ST_IDLE)
    else $error("load or assign left the block busy");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> rsp.last == ({1'b0, rsp.row_index} + 1'b1 == nrows))
    else $error("last flag does not match final row");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    state == rhvc_pkg::ST_EMIT && !emitting && emit_idx == rhvc_pkg::ROW_W'(NR - 1)
    |=> state == rhvc_pkg::ST_IDLE)
    else $error("ring rotation did not finish");

endmodule

/* tb/row_hamming_violation_counter_tb.sv */
`timescale 1ns / 100ps

module row_hamming_violation_counter_tb;

  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 90;
  localparam int PRELOAD_COLS = 4;
  localparam int NO_TYPED = -1;

  typedef struct {
    bit              is_cfg;
    rhvc_pkg::mode_t mode;
    int              column;
    int              row;
    bit              b;
    int              rows_v;
    int              cols_v;
    int              exp_n;
    int              exp_v;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  rhvc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rhvc_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [rhvc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rhvc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bit calm = 1'b0;
  int errors = 0;

  logic row_bits [rhvc_pkg::MAX_COLS][rhvc_pkg::MAX_ROWS] = '{default: 1'b0};
  bit known [rhvc_pkg::MAX_COLS][rhvc_pkg::MAX_ROWS] = '{default: 1'b0};
  logic var_bits [rhvc_pkg::MAX_COLS] = '{default: 1'b0};
  logic [rhvc_pkg::CNT_W-1:0] row_viol [rhvc_pkg::MAX_ROWS] = '{default: '0};
  logic [rhvc_pkg::ROWS_CFG_W-1:0] rows_cfg = 5'd16;
  logic [rhvc_pkg::COLS_CFG_W-1:0] cols_cfg = 7'd64;
  rhvc_pkg::rsp_t pending_counts [$];
  rhvc_pkg::rsp_t want;

  step_t script [22] = '{
    '{1'b0, rhvc_pkg::MODE_CHANGE,     5,  0, 1'b0,  0,   0,  0, 0},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     3,  0, 1'b1,  0,   0, 16, 1},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     3,  0, 1'b0,  0,   0, 16, 0},
    '{1'b1, rhvc_pkg::MODE_LOAD,       0,  0, 1'b0,  0,   0,  0, 0},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     1,  0, 1'b1,  0,   0,  0, 0},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     0,  0, 1'b1,  0,   0,  1, 1},
    '{1'b0, rhvc_pkg::MODE_LOAD,       0,  0, 1'b1,  0,   0,  0, 0},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     0,  0, 1'b0,  0,   0,  1, 1},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     0,  0, 1'b1,  0,   0,  1, 0},
    '{1'b0, rhvc_pkg::MODE_ASSIGN,     0,  0, 1'b0,  0,   0,  0, 0},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     0,  0, 1'b1,  0,   0,  1, 0},
    '{1'b1, rhvc_pkg::MODE_LOAD,       0,  0, 1'b0, 31, 127,  0, 0},
    '{1'b0, rhvc_pkg::MODE_LOAD,       3, 15, 1'b1,  0,   0,  0, 0},
    '{1'b0, rhvc_pkg::MODE_ASSIGN,     3,  0, 1'b1,  0,   0,  0, 0},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     2,  0, 1'b1,  0,   0, NO_TYPED, 0},
    '{1'b1, rhvc_pkg::MODE_LOAD,       0,  0, 1'b0, 16,   4,  0, 0},
    '{1'b0, rhvc_pkg::MODE_RECOMPUTE,  0,  0, 1'b0,  0,   0, NO_TYPED, 0},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     3,  0, 1'b0,  0,   0, NO_TYPED, 0},
    '{1'b1, rhvc_pkg::MODE_LOAD,       0,  0, 1'b0,  1,  64,  0, 0},
    '{1'b0, rhvc_pkg::MODE_CHANGE,     3,  0, 1'b1,  0,   0, NO_TYPED, 0},
    '{1'b1, rhvc_pkg::MODE_LOAD,       0,  0, 1'b0, 16,   0,  0, 0},
    '{1'b0, rhvc_pkg::MODE_RECOMPUTE,  0,  0, 1'b0,  0,   0, NO_TYPED, 0}
  };

  row_hamming_violation_counter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int rows_in_use();
    if (rows_cfg == 0) return 1;
    if (rows_cfg > rhvc_pkg::MAX_ROWS) return rhvc_pkg::MAX_ROWS;
    return int'(rows_cfg);
  endfunction

  function automatic int cols_in_use();
    if (cols_cfg == 0) return 1;
    if (cols_cfg > rhvc_pkg::MAX_COLS) return rhvc_pkg::MAX_COLS;
    return int'(cols_cfg);
  endfunction

  function automatic rhvc_pkg::req_t make_req(input rhvc_pkg::mode_t m, input int c,
                                              input int rw, input bit b);
    rhvc_pkg::req_t r;
    r.mode = m;
    r.column = c[rhvc_pkg::COL_W-1:0];
    r.row = rw[rhvc_pkg::ROW_W-1:0];
    r.bit_req = b;
    return r;
  endfunction

  function automatic void track_request(input rhvc_pkg::req_t r, input int exp_n,
                                        input int exp_v);
    int nr;
    int nc;
    int v;
    int emit;
    rhvc_pkg::rsp_t e;
    nr = rows_in_use();
    nc = cols_in_use();
    emit = 0;
    case (r.mode)
      rhvc_pkg::MODE_LOAD: begin
        row_bits[r.column][r.row] = r.bit_req;
        known[r.column][r.row] = 1'b1;
      end
      rhvc_pkg::MODE_ASSIGN: var_bits[r.column] = r.bit_req;
      rhvc_pkg::MODE_RECOMPUTE: begin
        for (int i = 0; i < nr; i++) begin
          v = 0;
          for (int c = 0; c < nc; c++)
            if (row_bits[c][i] != var_bits[c]) v++;
          row_viol[i] = rhvc_pkg::CNT_W'(v);
        end
        emit = nr;
      end
      rhvc_pkg::MODE_CHANGE: begin
        if (var_bits[r.column] != r.bit_req) begin
          var_bits[r.column] = r.bit_req;
          if (r.column < nc) begin
            // saturate at zero and at the columns in use
            for (int i = 0; i < nr; i++) begin
              if (row_bits[r.column][i] == r.bit_req) begin
                if (row_viol[i] > 0) row_viol[i]--;
              end else if (row_viol[i] < nc) begin
                row_viol[i]++;
              end
            end
            emit = nr;
          end
        end
      end
      default: begin
      end
    endcase
    if (exp_n != NO_TYPED) emit = exp_n;
    for (int i = 0; i < emit; i++) begin
      e.row_index = rhvc_pkg::ROW_W'(i);
      e.violations = (exp_n != NO_TYPED) ? rhvc_pkg::CNT_W'(exp_v) : row_viol[i];
      e.last = (i == emit - 1);
      pending_counts.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic push_request(input rhvc_pkg::req_t r, input int exp_n, input int exp_v);
    while (!calm && $urandom_range(99) < 14) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    track_request(r, exp_n, exp_v);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input int rows_v, input int cols_v);
    cfg_we <= 1'b1;
    cfg_index <= rhvc_pkg::REG_ROWS_USED;
    cfg_data <= rhvc_pkg::CFG_DATA_W'(rows_v);
    @(posedge clk);
    cfg_index <= rhvc_pkg::REG_COLS_USED;
    cfg_data <= rhvc_pkg::CFG_DATA_W'(cols_v);
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_cfg = rhvc_pkg::ROWS_CFG_W'(rows_v);
    cols_cfg = rhvc_pkg::COLS_CFG_W'(cols_v);
  endtask

  function automatic rhvc_pkg::req_t random_request();
    rhvc_pkg::req_t r;
    int nr;
    int nc;
    int pick;
    int gap_c;
    int gap_r;
    nr = rows_in_use();
    nc = cols_in_use();
    pick = $urandom_range(99);
    r.bit_req = 1'($urandom_range(1));
    r.row = rhvc_pkg::ROW_W'(($urandom_range(9) < 8) ? $urandom_range(nr - 1)
                                                      : $urandom_range(rhvc_pkg::MAX_ROWS - 1));
    r.column = rhvc_pkg::COL_W'(($urandom_range(9) < 8) ? $urandom_range(nc - 1)
                                                         : $urandom_range(rhvc_pkg::MAX_COLS - 1));
    if (pick < 30) r.mode = rhvc_pkg::MODE_LOAD;
    else if (pick < 42) r.mode = rhvc_pkg::MODE_ASSIGN;
    else if (pick < 57) r.mode = rhvc_pkg::MODE_RECOMPUTE;
    else r.mode = rhvc_pkg::MODE_CHANGE;
    gap_c = -1;
    gap_r = 0;
    if (r.mode == rhvc_pkg::MODE_RECOMPUTE) begin
      for (int c = 0; c < nc; c++)
        for (int i = 0; i < nr; i++)
          if (!known[c][i] && gap_c < 0) begin
            gap_c = c;
            gap_r = i;
          end
    end else if (r.mode == rhvc_pkg::MODE_CHANGE && var_bits[r.column] != r.bit_req &&
                 r.column < nc) begin
      for (int i = 0; i < nr; i++)
        if (!known[r.column][i] && gap_c < 0) begin
          gap_c = int'(r.column);
          gap_r = i;
        end
    end
    if (gap_c >= 0) begin
      // load a bit that the request would read before it is ever written
      r.mode = rhvc_pkg::MODE_LOAD;
      r.column = gap_c[rhvc_pkg::COL_W-1:0];
      r.row = gap_r[rhvc_pkg::ROW_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) rsp_stall <= !calm && ($urandom_range(99) < 14);

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction row %0d", rsp.row_index));
      end else begin
        want = pending_counts.pop_front();
        if (rsp.row_index !== want.row_index)
          report_mismatch($sformatf("row_index %0d, want %0d", rsp.row_index, want.row_index));
        if (rsp.violations !== want.violations)
          report_mismatch($sformatf("row %0d violations %0d, want %0d",
                                    want.row_index, rsp.violations, want.violations));
        if (rsp.last !== want.last)
          report_mismatch($sformatf("row %0d last %0b, want %0b",
                                    want.row_index, rsp.last, want.last));
      end
    end
  end

  initial begin
    #2000000;
    $display("row_hamming_violation_counter_tb: FAIL");
    $finish;
  end

  initial begin
    int made;
    int span;
    int rows_v;
    int cols_v;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // clear the first columns of every row so that the directed reads are defined
    for (int c = 0; c < PRELOAD_COLS; c++)
      for (int rw = 0; rw < rhvc_pkg::MAX_ROWS; rw++)
        push_request(make_req(rhvc_pkg::MODE_LOAD, c, rw, 1'b0), NO_TYPED, 0);

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        drain();
        write_regs(script[k].rows_v, script[k].cols_v);
      end else begin
        push_request(make_req(script[k].mode, script[k].column, script[k].row, script[k].b),
                     script[k].exp_n, script[k].exp_v);
      end
    end

    made = 0;
    while (made < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(5))
        0: rows_v = 0;
        1: rows_v = 1;
        2: rows_v = $urandom_range(17, 31);
        3: rows_v = rhvc_pkg::MAX_ROWS;
        default: rows_v = $urandom_range(1, rhvc_pkg::MAX_ROWS);
      endcase
      case ($urandom_range(5))
        0: cols_v = 0;
        1: cols_v = 1;
        2: cols_v = $urandom_range(65, 127);
        3: cols_v = rhvc_pkg::MAX_COLS;
        default: cols_v = $urandom_range(1, 12);
      endcase
      write_regs(rows_v, cols_v);
      span = $urandom_range(8, 30);
      for (int k = 0; k < span && made < RANDOM_ITEMS; k++) begin
        calm = (made >= 30 && made < 60);
        // hold until every count has come back
        if (made == 70) drain();
        push_request(random_request(), NO_TYPED, 0);
        made++;
      end
    end
    calm = 1'b0;
    drain();

    if (errors == 0) begin
      $display("row_hamming_violation_counter_tb: PASS");
    end else begin
      $display("row_hamming_violation_counter_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rhvc_pkg.sv
sv/rhvc_table.sv
sv/rhvc_cell.sv
sv/row_hamming_violation_counter.sv
tb/row_hamming_violation_counter_tb.sv
